### src/fcc_pkg.sv
package fcc_pkg;

    // Built depth of the tap store and of the sample history.
    localparam int MAX_TAPS = 64;
    localparam int TAP_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);

    // Fixed field widths of the channels and of the register.
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 6;
    localparam int CFG_W    = 7;

    // One complex value as held in the history and the tap store.
    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } t_cplx;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic             load;
        logic [TAP_W-1:0] load_addr;
        t_cplx            load_data;
        logic             clear;
        logic             term;
        logic [TAP_W-1:0] coef_addr;
    } t_mac_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_DONE
    } t_state;

    // Command codes of the input item.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

endpackage

### src/fcc_if.sv
// Input channel: coefficient loads and samples.
interface fcc_in_if;
    logic                valid;
    logic                ready;
    logic                command;
    logic [5:0]          tap_index;
    logic signed [31:0]  data_re;
    logic signed [31:0]  data_im;
    logic                frame_start;

    modport source (
        output valid, command, tap_index, data_re, data_im, frame_start,
        input  ready
    );
    modport sink (
        input  valid, command, tap_index, data_re, data_im, frame_start,
        output ready
    );
endinterface

// Output channel: filter results.
interface fcc_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  result_re;
    logic signed [31:0]  result_im;

    modport source (
        output valid, result_re, result_im,
        input  ready
    );
    modport sink (
        input  valid, result_re, result_im,
        output ready
    );
endinterface

### src/complex_fir_correlator_core.sv
// Complex FIR correlator over signed 32-bit complex samples.
// Input channel i_in carries two kinds of transfer: a coefficient load
// (command low) writes one tap, a sample (command high) enters the history.
// Output channel o_out carries one complex result per qualifying sample.
// The tap count is written through i_cfg_we / i_cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// A sample that yields a result holds off the next transfer: the history
// chain rotates once past a single complex multiply-accumulate unit, then
// the pipeline drains through ST_DRAIN1 and ST_DRAIN2, and in ST_DONE the
// result is placed in the output register once that register is free.
// A load, or a sample that completes no window, leaves the block idle.
// Reset clears the fill count, the sequencer and the output valid flag and
// sets the tap count to 64; the tap store holds nothing until loaded.
// A stalled receiver keeps the result in the output register; a new item
// is still taken meanwhile, and a later result waits in its final state
// until the register is free.
module complex_fir_correlator_core
    import fcc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    fcc_in_if.sink           i_in,
    fcc_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    t_state             r_state;
    t_state             n_state;
    logic [TAP_W-1:0]   r_count;
    logic [TAP_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_taps;
    logic [CNT_W-1:0]   r_fill;
    logic [CFG_W-1:0]   r_active_taps;
    logic               r_out_valid;
    logic               n_out_valid;
    t_cplx              r_out;

    logic               w_xfer;
    logic               w_sample;
    logic               w_load;
    logic [CNT_W-1:0]   w_taps;
    logic [CNT_W-1:0]   w_fill_next;
    logic               w_emit;
    logic               w_shift;
    logic               w_out_free;
    t_cplx              w_head;
    t_cplx              w_hist [MAX_TAPS];
    t_cplx              w_acc;
    t_mac_ctrl          w_ctrl;

    // Tap count in use: zero means one, larger than the build saturates.
    function automatic logic [CNT_W-1:0] taps_in_use(input logic [CFG_W-1:0] cfg);
        logic [CNT_W-1:0] n;
        if (cfg == '0) begin
            n = CNT_W'(1);
        end else if (32'(cfg) > MAX_TAPS) begin
            n = CNT_W'(MAX_TAPS);
        end else begin
            n = CNT_W'(cfg);
        end
        return n;
    endfunction

    // Input transfer decode.
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_xfer     = i_in.valid && i_in.ready;
    assign w_sample   = w_xfer && (i_in.command == CMD_SAMPLE);
    assign w_load     = w_xfer && (i_in.command == CMD_LOAD) &&
                        (32'(i_in.tap_index) < MAX_TAPS);
    assign w_out_free = !r_out_valid || o_out.ready;

    // Fill count after this sample, and whether its window is complete.
    assign w_taps = taps_in_use(r_active_taps);
    always_comb begin
        if (i_in.frame_start) begin
            w_fill_next = CNT_W'(1);
        end else if (32'(r_fill) < MAX_TAPS) begin
            w_fill_next = r_fill + CNT_W'(1);
        end else begin
            w_fill_next = r_fill;
        end
    end
    assign w_emit = (w_fill_next >= w_taps);

    // History chain: a new sample enters at the head; while running the
    // tail wraps back to the head so the line is restored after one lap.
    assign w_shift = w_sample || (r_state == ST_RUN);
    always_comb begin
        if (r_state == ST_RUN) begin
            w_head = w_hist[MAX_TAPS-1];
        end else begin
            w_head.re = i_in.data_re;
            w_head.im = i_in.data_im;
        end
    end

    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
        if (g == 0) begin : g_head
            fcc_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_data  (w_head),
                .o_data  (w_hist[g])
            );
        end else begin : g_body
            fcc_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_data  (w_hist[g-1]),
                .o_data  (w_hist[g])
            );
        end
    end

    // After r steps the tail holds history entry MAX_TAPS-1-r; the window
    // starts at step MAX_TAPS-n, where tap zero meets the oldest sample.
    always_comb begin
        w_ctrl.load         = w_load;
        w_ctrl.load_addr    = TAP_W'(i_in.tap_index);
        w_ctrl.load_data.re = i_in.data_re;
        w_ctrl.load_data.im = i_in.data_im;
        w_ctrl.clear        = w_sample;
        w_ctrl.term         = (r_state == ST_RUN) &&
                              ((32'(r_count) + 32'(r_taps)) >= MAX_TAPS);
        w_ctrl.coef_addr    = TAP_W'(32'(r_count) + 32'(r_taps) - MAX_TAPS);
    end

    fcc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_x     (w_hist[MAX_TAPS-1]),
        .o_acc   (w_acc)
    );

    // Sequencer: next state and output register control.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_out.ready;
        case (r_state)
            ST_IDLE: begin
                if (w_sample && w_emit) begin
                    n_state = ST_RUN;
                    n_count = '0;
                end
            end
            ST_RUN: begin
                if (32'(r_count) == MAX_TAPS - 1) begin
                    n_state = ST_DRAIN1;
                end else begin
                    n_count = r_count + TAP_W'(1);
                end
            end
            ST_DRAIN1: begin
                n_state = ST_DRAIN2;
            end
            ST_DRAIN2: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= '0;
            r_taps        <= CNT_W'(1);
            r_fill        <= '0;
            r_active_taps <= CFG_W'(64);
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_active_taps <= i_cfg_wdata;
            end
            if (w_sample) begin
                r_fill <= w_fill_next;
                r_taps <= w_taps;
            end
        end
    end

    // Result register, loaded when the accumulation has drained.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out <= w_acc;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.result_re = r_out.re;
    assign o_out.result_im = r_out.im;

    // A sample that completes a window starts the lap of the chain.
    a_emit_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sample && w_emit) |=> (r_state == ST_RUN && r_count == '0))
        else $error("qualifying sample did not start accumulation");

    // The lap ends after the last step and the pipeline then drains.
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && 32'(r_count) == MAX_TAPS - 1) |=> (r_state == ST_DRAIN1))
        else $error("accumulation lap did not end on its last step");

    // A finished result reaches the output register once it is free.
    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished result not placed in the output register");

    // No input transfer is taken while an accumulation is in flight.
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN || r_state == ST_DRAIN1 || r_state == ST_DRAIN2) |-> !w_xfer)
        else $error("input transfer taken during accumulation");

endmodule

### src/fcc_cell.sv
module fcc_cell
    import fcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_cplx i_data,
    output t_cplx o_data
);

    t_cplx r_data;

    // Each cell takes its neighbour's sample whenever the line moves; the head cell takes the head input.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

### src/fcc_mac.sv
module fcc_mac
    import fcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mac_ctrl i_ctrl,
    input  t_cplx     i_x,
    output t_cplx     o_acc
);

    t_cplx             r_coef [MAX_TAPS];
    t_cplx             r_coef_rd;
    t_cplx             r_x;
    logic              r_v1;
    logic              r_v2;
    logic [DATA_W-1:0] r_prr;
    logic [DATA_W-1:0] r_pii;
    logic [DATA_W-1:0] r_pri;
    logic [DATA_W-1:0] r_pir;
    t_cplx             r_acc;

    // Tap store: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_coef[i_ctrl.load_addr] <= i_ctrl.load_data;
        end
        r_coef_rd <= r_coef[i_ctrl.coef_addr];
    end

    // Term flags travel alongside the data through the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctrl.term;
            r_v2 <= r_v1;
        end
    end

    // Stage one registers the sample leaving the tail of the line.
    always_ff @(posedge i_clk) begin
        r_x <= i_x;
    end

    // Stage two forms the four partial products, wrapped to 32 bits.
    always_ff @(posedge i_clk) begin
        r_prr <= DATA_W'(r_x.re * r_coef_rd.re);
        r_pii <= DATA_W'(r_x.im * r_coef_rd.im);
        r_pri <= DATA_W'(r_x.re * r_coef_rd.im);
        r_pir <= DATA_W'(r_coef_rd.re * r_x.im);
    end

    // Stage three accumulates the complex product.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_acc.re <= '0;
            r_acc.im <= '0;
        end else if (r_v2) begin
            r_acc.re <= r_acc.re + $signed(r_prr - r_pii);
            r_acc.im <= r_acc.im + $signed(r_pri + r_pir);
        end
    end

    assign o_acc = r_acc;

endmodule

### test/complex_fir_correlator_core_tb.sv
module complex_fir_correlator_core_tb;
    import fcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One input transfer as the sender sees it.
    typedef struct packed {
        logic                     command;
        logic [INDEX_W-1:0]       tap_index;
        logic signed [DATA_W-1:0] data_re;
        logic signed [DATA_W-1:0] data_im;
        logic                     frame_start;
    } t_fir_item;

    // One row of the directed stimulus: either a tap count write or a transfer.
    typedef struct {
        bit               cfg_row;
        logic [CFG_W-1:0] taps;
        t_fir_item        item;
        bit               typed;
        t_cplx            y;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    fcc_in_if  in_if ();
    fcc_out_if out_if ();

    complex_fir_correlator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Filter state as the block should hold it.
    t_cplx            coef_taps [MAX_TAPS];
    bit               tap_written [MAX_TAPS];
    t_cplx            history [MAX_TAPS];
    int               fill_level;
    logic [CFG_W-1:0] taps_setting;

    t_cplx     pending_results[$];
    t_stim_row stim_rows[$];
    int        mismatch_count = 0;
    bit        stall_enable   = 1'b1;
    bit        gaps_enable    = 1'b1;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Advances the filter state by one accepted transfer; returns 1 with the tap sum
    // when the transfer completes a window.
    function automatic bit fir_advance(input t_fir_item it, output t_cplx y);
        int          n;
        int          k;
        logic [31:0] acc_re;
        logic [31:0] acc_im;
        t_cplx       x;
        t_cplx       c;
        y = '0;
        if (it.command == CMD_LOAD) begin
            coef_taps[it.tap_index]   = '{re: it.data_re, im: it.data_im};
            tap_written[it.tap_index] = 1'b1;
            return 1'b0;
        end
        if (it.frame_start) begin
            fill_level = 0;
        end
        for (k = MAX_TAPS - 1; k > 0; k--) begin
            history[k] = history[k-1];
        end
        history[0] = '{re: it.data_re, im: it.data_im};
        if (fill_level < MAX_TAPS) begin
            fill_level++;
        end
        n = (taps_setting == 0) ? 1 : (taps_setting > MAX_TAPS) ? MAX_TAPS : int'(taps_setting);
        if (fill_level < n) begin
            return 1'b0;
        end
        // Oldest sample of the window meets tap 0; everything wraps at 32 bits.
        acc_re = '0;
        acc_im = '0;
        for (k = 0; k < n; k++) begin
            x = history[n-1-k];
            c = coef_taps[k];
            acc_re += x.re * c.re - x.im * c.im;
            acc_im += x.re * c.im + c.re * x.im;
        end
        y.re = acc_re;
        y.im = acc_im;
        return 1'b1;
    endfunction

    // Data words lean towards the extremes and small values now and then.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_cfg(input logic [CFG_W-1:0] v);
        t_stim_row r;
        r         = '{default: '0};
        r.cfg_row = 1'b1;
        r.taps    = v;
        stim_rows.push_back(r);
    endtask

    task automatic add_item(input logic cmd, input logic [INDEX_W-1:0] tap,
                            input logic [31:0] re, input logic [31:0] im, input logic fs,
                            input bit typed, input logic [31:0] yre, input logic [31:0] yim);
        t_stim_row r;
        r      = '{default: '0};
        r.item = '{command: cmd, tap_index: tap, data_re: re, data_im: im, frame_start: fs};
        r.typed = typed;
        r.y     = '{re: yre, im: yim};
        stim_rows.push_back(r);
    endtask

    task automatic pause_input(input int cycles);
        in_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if (gaps_enable && $urandom_range(0, 5) == 0) begin
            pause_input($urandom_range(1, 12));
        end
    endtask

    // Holds the sender until every outstanding result has been transferred.
    task automatic drain_results();
        pause_input(1);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Drain, then let any result-free work still in the block finish.
    task automatic settle_block();
        drain_results();
        repeat (MAX_TAPS + 8) @(posedge i_clk);
    endtask

    task automatic write_taps(input logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        taps_setting = v;
    endtask

    // Presents one item, waits for its transfer and books the expected result.
    task automatic transfer_item(input t_fir_item it, input bit typed, input t_cplx typed_y);
        t_cplx y;
        in_if.valid       <= 1'b1;
        in_if.command     <= it.command;
        in_if.tap_index   <= it.tap_index;
        in_if.data_re     <= it.data_re;
        in_if.data_im     <= it.data_im;
        in_if.frame_start <= it.frame_start;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (fir_advance(it, y)) begin
            pending_results.push_back(typed ? typed_y : y);
        end
    endtask

    task automatic random_load(input logic [INDEX_W-1:0] tap);
        t_fir_item it;
        it = '{command: CMD_LOAD, tap_index: tap, data_re: pick_word(), data_im: pick_word(),
               frame_start: 1'($urandom_range(0, 1))};
        transfer_item(it, 1'b0, '0);
        maybe_gap();
    endtask

    // Random receiver pauses; the receiver side runs on its own.
    initial begin : result_backpressure
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_enable && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
        end
    end

    // Every result transfer is compared with the oldest booked result.
    always @(posedge i_clk) begin
        t_cplx want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result re=%0d im=%0d", out_if.result_re, out_if.result_im);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_if.result_re !== want.re) begin
                    $error("result_re: expected %0d, actual %0d", want.re, out_if.result_re);
                    mismatch_count++;
                end
                if (out_if.result_im !== want.im) begin
                    $error("result_im: expected %0d, actual %0d", want.im, out_if.result_im);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #4_800_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int               phase_taps [8] = '{127, 1, 5, 0, 12, 64, 33, 3};
        int               phase_items [8] = '{60, 40, 45, 25, 45, 55, 30, 25};
        int               n;
        int               p;
        int               i;
        int               t;
        t_fir_item        it;
        t_stim_row        r;

        // Known levels on every input from the start.
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        in_if.valid       <= 1'b0;
        in_if.command     <= CMD_LOAD;
        in_if.tap_index   <= '0;
        in_if.data_re     <= '0;
        in_if.data_im     <= '0;
        in_if.frame_start <= 1'b0;

        foreach (history[k]) begin
            history[k]     = '0;
            coef_taps[k]   = '0;
            tap_written[k] = 1'b0;
        end
        fill_level   = 0;
        taps_setting = 7'd64;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. At the reset tap count a lone sample completes nothing.
        add_item(CMD_SAMPLE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0, 0);
        // A tap count of zero behaves as a single tap.
        add_cfg(7'd0);
        add_item(CMD_LOAD, 0, 1, 0, 1, 0, 0, 0);
        add_item(CMD_SAMPLE, 0, 5, -7, 0, 1, 5, -7);
        add_item(CMD_SAMPLE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1,
                 32'h7FFF_FFFF, 32'h8000_0000);
        add_item(CMD_LOAD, 0, -1, 0, 0, 0, 0, 0);
        add_item(CMD_SAMPLE, 0, 32'h8000_0000, 1, 0, 1, 32'h8000_0000, -1);
        add_item(CMD_LOAD, 0, 0, 1, 0, 0, 0, 0);
        add_item(CMD_SAMPLE, 0, 3, 4, 0, 1, -4, 3);
        add_item(CMD_LOAD, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0);
        add_item(CMD_SAMPLE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0);
        add_item(CMD_LOAD, 63, -1, 32'h8000_0000, 0, 0, 0, 0);
        add_item(CMD_SAMPLE, 0, 0, 0, 1, 1, 0, 0);
        // Two taps: the oldest sample meets tap 0, a frame start refills first.
        add_cfg(7'd2);
        add_item(CMD_LOAD, 0, 1, 0, 0, 0, 0, 0);
        add_item(CMD_LOAD, 1, 0, 0, 1, 0, 0, 0);
        add_item(CMD_SAMPLE, 0, 10, 20, 1, 0, 0, 0);
        add_item(CMD_SAMPLE, 0, 30, 40, 0, 1, 10, 20);
        add_item(CMD_SAMPLE, 63, 7, 8, 1, 0, 0, 0);
        add_item(CMD_LOAD, 1, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
        add_item(CMD_SAMPLE, 42, -1, -1, 0, 0, 0, 0);
        add_item(CMD_LOAD, 62, 32'h5555_AAAA, 32'hAAAA_5555, 1, 0, 0, 0);

        foreach (stim_rows[k]) begin
            r = stim_rows[k];
            if (r.cfg_row) begin
                settle_block();
                write_taps(r.taps);
            end else begin
                transfer_item(r.item, r.typed, r.y);
                maybe_gap();
            end
        end

        // Random phases, each at its own tap count; most are short filters.
        for (p = 0; p < 8; p++) begin
            settle_block();
            write_taps(CFG_W'(phase_taps[p]));
            n = (phase_taps[p] == 0) ? 1 : (phase_taps[p] > MAX_TAPS) ? MAX_TAPS : phase_taps[p];
            stall_enable = (p != 7) && ($urandom_range(0, 3) != 0);
            gaps_enable  = (p != 7) && ($urandom_range(0, 3) != 0);

            // Every tap that a window reads is loaded before any sample.
            for (t = 0; t < n; t++) begin
                if (!tap_written[t]) begin
                    random_load(INDEX_W'(t));
                end
            end

            for (i = 0; i < phase_items[p]; i++) begin
                // Hold the sender once per phase until the block has caught up.
                if (i == phase_items[p] / 2) begin
                    drain_results();
                end
                if ($urandom_range(0, 99) < 12) begin
                    random_load(INDEX_W'($urandom_range(0, MAX_TAPS - 1)));
                end else begin
                    it = '{command: CMD_SAMPLE,
                           tap_index: INDEX_W'($urandom_range(0, MAX_TAPS - 1)),
                           data_re: pick_word(), data_im: pick_word(),
                           frame_start: ($urandom_range(0, 3 * n + 4) == 0)};
                    transfer_item(it, 1'b0, '0);
                    maybe_gap();
                end
            end
        end

        drain_results();
        repeat (MAX_TAPS + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
src/fcc_pkg.sv
src/fcc_if.sv
src/fcc_cell.sv
src/fcc_mac.sv
src/complex_fir_correlator_core.sv
test/complex_fir_correlator_core_tb.sv
